/* src/obbsat_pkg.sv */
// Shared constants, types and the quarter-wave sine table of the box overlap test.
`timescale 1ns / 1ps
package obbsat_pkg;

	localparam int COORD_BITS     = 24;
	localparam int ANGLE_BITS     = 12;
	localparam int TRIG_FRAC_BITS = 15;

	localparam int QUARTER_BITS = ANGLE_BITS - 2;
	localparam int QUARTER      = 1 << QUARTER_BITS;
	localparam int ROM_AW       = QUARTER_BITS + 1;
	localparam int SINE_W       = TRIG_FRAC_BITS + 1;
	localparam int TRIG_W       = TRIG_FRAC_BITS + 2;
	localparam int SIZE_BITS    = COORD_BITS - 1;
	localparam int DIFF_W       = COORD_BITS + 1;
	localparam int DPROD_W      = DIFF_W + TRIG_W;
	localparam int DSUM_W       = DPROD_W + 1;
	localparam int DABS_W       = COORD_BITS + TRIG_FRAC_BITS + 2;
	localparam int CPROD_W      = 2 * TRIG_W;
	localparam int CSUM_W       = CPROD_W + 1;
	localparam int PABS_W       = 2 * TRIG_FRAC_BITS + 2;
	localparam int SPROD_W      = SIZE_BITS + PABS_W;
	localparam int ACC_W        = SPROD_W + 2;
	localparam int LHS_W        = DABS_W + TRIG_FRAC_BITS + 1;
	localparam int CMP_W        = (ACC_W > LHS_W) ? ACC_W : LHS_W;
	localparam int NUM_AXES     = 4;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned TAYLOR_DIV [1:10] =
		'{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

	typedef logic [SINE_W-1:0] sine_rom_t [0:QUARTER];

	typedef struct packed {
		logic signed [TRIG_W-1:0] co;
		logic signed [TRIG_W-1:0] si;
	} box_trig_t;

	typedef struct packed {
		logic s1;
		logic s2;
	} trig_en_t;

	typedef struct packed {
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} axis_en_t;

	// Taylor series of sine in Q30, rounded to the trig fraction width
	function automatic sine_rom_t build_sine();
		sine_rom_t         t;
		longint unsigned   x;
		longint unsigned   x2;
		longint unsigned   term;
		longint            s;
		longint            v;
		int                k;
		int                n;
		for (k = 0; k <= QUARTER; k++) begin
			x    = (longint'(k) * HALF_PI_Q30) >> QUARTER_BITS;
			x2   = (x * x) >> 30;
			term = x;
			s    = longint'(x);
			for (n = 1; n <= 10; n++) begin
				term = ((term * x2) >> 30) / TAYLOR_DIV[n];
				if ((n & 1) != 0) begin
					s = s - longint'(term);
				end else begin
					s = s + longint'(term);
				end
			end
			if (s < 0) begin
				s = 0;
			end
			v = (s + (64'sd1 <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
			if (v > (64'sd1 <<< TRIG_FRAC_BITS)) begin
				v = 64'sd1 <<< TRIG_FRAC_BITS;
			end
			t[k] = SINE_W'(v);
		end
		return t;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine();

endpackage

/* src/obbsat_if.sv */
// Handshake channels for box pairs and overlap results.
`timescale 1ns / 1ps
interface obbsat_in_if import obbsat_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] first_center_x;
	logic signed [COORD_BITS-1:0] first_center_y;
	logic        [SIZE_BITS-1:0]  first_size_x;
	logic        [SIZE_BITS-1:0]  first_size_y;
	logic        [ANGLE_BITS-1:0] first_angle;
	logic signed [COORD_BITS-1:0] second_center_x;
	logic signed [COORD_BITS-1:0] second_center_y;
	logic        [SIZE_BITS-1:0]  second_size_x;
	logic        [SIZE_BITS-1:0]  second_size_y;
	logic        [ANGLE_BITS-1:0] second_angle;

	modport source (
		output valid, first_center_x, first_center_y, first_size_x, first_size_y,
		       first_angle, second_center_x, second_center_y, second_size_x,
		       second_size_y, second_angle,
		input  ready
	);
	modport sink (
		input  valid, first_center_x, first_center_y, first_size_x, first_size_y,
		       first_angle, second_center_x, second_center_y, second_size_x,
		       second_size_y, second_angle,
		output ready
	);
endinterface

interface obbsat_out_if;
	logic valid;
	logic ready;
	logic overlap;

	modport source (output valid, overlap, input ready);
	modport sink (input valid, overlap, output ready);
endinterface

/* src/obbsat_trig.sv */
// Sine and cosine of one box angle from the quarter-wave ROM, two stages.
`timescale 1ns / 1ps
module obbsat_trig import obbsat_pkg::*; (
	input  logic                  clk,
	input  trig_en_t              en,
	input  logic [ANGLE_BITS-1:0] angle,
	output box_trig_t             trig_s2
);

	localparam logic [1:0] QUAD_I   = 2'd0;
	localparam logic [1:0] QUAD_II  = 2'd1;
	localparam logic [1:0] QUAD_III = 2'd2;

	logic [QUARTER_BITS-1:0] r;
	logic [ROM_AW-1:0]       addr_lo;
	logic [ROM_AW-1:0]       addr_hi;
	logic [SINE_W-1:0]       lo_s1;
	logic [SINE_W-1:0]       hi_s1;
	logic [1:0]              quad_s1;
	logic signed [TRIG_W-1:0] lo_p;
	logic signed [TRIG_W-1:0] hi_p;
	box_trig_t               trig_d;

	assign r       = angle[QUARTER_BITS-1:0];
	assign addr_lo = {1'b0, r};
	assign addr_hi = ROM_AW'(QUARTER) - {1'b0, r};

	always_ff @(posedge clk) begin
		if (en.s1) begin
			lo_s1   <= SINE_ROM[addr_lo];
			hi_s1   <= SINE_ROM[addr_hi];
			quad_s1 <= angle[ANGLE_BITS-1 -: 2];
		end
	end

	assign lo_p = $signed({1'b0, lo_s1});
	assign hi_p = $signed({1'b0, hi_s1});

	always_comb begin
		case (quad_s1)
			QUAD_I: begin
				trig_d.si = lo_p;
				trig_d.co = hi_p;
			end
			QUAD_II: begin
				trig_d.si = hi_p;
				trig_d.co = -lo_p;
			end
			QUAD_III: begin
				trig_d.si = -lo_p;
				trig_d.co = -hi_p;
			end
			default: begin
				trig_d.si = -hi_p;
				trig_d.co = lo_p;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			trig_s2 <= trig_d;
		end
	end

endmodule

/* src/obbsat_axis.sv */
// One separating-axis lane: projections, size products and the strict-gap compare.
`timescale 1ns / 1ps
module obbsat_axis import obbsat_pkg::*; (
	input  logic                     clk,
	input  axis_en_t                 en,
	input  logic signed [TRIG_W-1:0] ux,
	input  logic signed [TRIG_W-1:0] uy,
	input  box_trig_t                trig [2],
	input  logic signed [DIFF_W-1:0] dx,
	input  logic signed [DIFF_W-1:0] dy,
	input  logic [SIZE_BITS-1:0]     size_x [2],
	input  logic [SIZE_BITS-1:0]     size_y [2],
	output logic                     sep_s6
);

	logic signed [DPROD_W-1:0] pdx_s3;
	logic signed [DPROD_W-1:0] pdy_s3;
	logic signed [CPROD_W-1:0] pxa_s3 [2];
	logic signed [CPROD_W-1:0] pxb_s3 [2];
	logic signed [CPROD_W-1:0] pya_s3 [2];
	logic signed [CPROD_W-1:0] pyb_s3 [2];

	logic [DABS_W-1:0] d_s4;
	logic [PABS_W-1:0] px_s4 [2];
	logic [PABS_W-1:0] py_s4 [2];

	logic [LHS_W-1:0]   lhs_s5;
	logic [SPROD_W-1:0] mx_s5 [2];
	logic [SPROD_W-1:0] my_s5 [2];

	logic signed [DSUM_W-1:0] dsum;
	logic [DSUM_W-1:0]        dmag;
	logic signed [CSUM_W-1:0] xsum [2];
	logic signed [CSUM_W-1:0] ysum [2];
	logic [CSUM_W-1:0]        xmag [2];
	logic [CSUM_W-1:0]        ymag [2];
	logic [CMP_W-1:0]         acc;
	logic [CMP_W-1:0]         lhs_ext;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			pdx_s3 <= dx * ux;
			pdy_s3 <= dy * uy;
			for (int b = 0; b < 2; b++) begin
				pxa_s3[b] <= trig[b].co * ux;
				pxb_s3[b] <= trig[b].si * uy;
				pya_s3[b] <= trig[b].co * uy;
				pyb_s3[b] <= trig[b].si * ux;
			end
		end
	end

	// magnitudes of the centre offset and of each box axis on this axis
	always_comb begin
		dsum = DSUM_W'(pdx_s3) + DSUM_W'(pdy_s3);
		dmag = dsum[DSUM_W-1] ? DSUM_W'(-dsum) : DSUM_W'(dsum);
		for (int b = 0; b < 2; b++) begin
			xsum[b] = CSUM_W'(pxa_s3[b]) + CSUM_W'(pxb_s3[b]);
			ysum[b] = CSUM_W'(pya_s3[b]) - CSUM_W'(pyb_s3[b]);
			xmag[b] = xsum[b][CSUM_W-1] ? CSUM_W'(-xsum[b]) : CSUM_W'(xsum[b]);
			ymag[b] = ysum[b][CSUM_W-1] ? CSUM_W'(-ysum[b]) : CSUM_W'(ysum[b]);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			d_s4 <= dmag[DABS_W-1:0];
			for (int b = 0; b < 2; b++) begin
				px_s4[b] <= xmag[b][PABS_W-1:0];
				py_s4[b] <= ymag[b][PABS_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			lhs_s5 <= {d_s4, {(TRIG_FRAC_BITS + 1){1'b0}}};
			for (int b = 0; b < 2; b++) begin
				mx_s5[b] <= SPROD_W'(size_x[b]) * SPROD_W'(px_s4[b]);
				my_s5[b] <= SPROD_W'(size_y[b]) * SPROD_W'(py_s4[b]);
			end
		end
	end

	always_comb begin
		acc = CMP_W'(mx_s5[0]) + CMP_W'(my_s5[0]) + CMP_W'(mx_s5[1]) + CMP_W'(my_s5[1]);
		lhs_ext = CMP_W'(lhs_s5);
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			sep_s6 <= (lhs_ext > acc);
		end
	end

endmodule

/* src/obb_pair_separating_axis_test.sv */
// Top level of the oriented box pair overlap test: trig lanes, four axis lanes, merge.
//
//  channel | modport | carries
//  --------+---------+-------------------------------------------------
//  boxes   | sink    | centres, full sizes and angles of both boxes
//  result  | source  | overlap flag, 1 when the boxes overlap or touch
//
// One box pair is taken every cycle while the result is not held back; each pair
// passes through ROM read, sign select, three lane stages, gap compare and merge.
// The seven stages each hold a valid bit and advance when the stage ahead is
// empty or moving, so a waiting result never blocks the bubbles behind it.
// Reset clears the valid bits only; the sine ROM is constant, no fill pass.
`timescale 1ns / 1ps
module obb_pair_separating_axis_test import obbsat_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	obbsat_in_if.sink     boxes,
	obbsat_out_if.source  result
);

	logic [7:1] vld_q;
	logic [7:1] adv;

	trig_en_t  trig_en;
	axis_en_t  axis_en;
	box_trig_t trig_s2 [2];

	logic signed [DIFF_W-1:0] dx_s1;
	logic signed [DIFF_W-1:0] dy_s1;
	logic signed [DIFF_W-1:0] dx_s2;
	logic signed [DIFF_W-1:0] dy_s2;

	logic [SIZE_BITS-1:0] size_x_s1 [2];
	logic [SIZE_BITS-1:0] size_y_s1 [2];
	logic [SIZE_BITS-1:0] size_x_s2 [2];
	logic [SIZE_BITS-1:0] size_y_s2 [2];
	logic [SIZE_BITS-1:0] size_x_s3 [2];
	logic [SIZE_BITS-1:0] size_y_s3 [2];
	logic [SIZE_BITS-1:0] size_x_s4 [2];
	logic [SIZE_BITS-1:0] size_y_s4 [2];

	logic signed [TRIG_W-1:0] ax_ux [NUM_AXES];
	logic signed [TRIG_W-1:0] ax_uy [NUM_AXES];
	logic [NUM_AXES-1:0]      sep_s6;
	logic                     overlap_q;

	// advance a stage when it is empty or its contents move on
	always_comb begin
		adv[7] = !vld_q[7] || result.ready;
		for (int k = 6; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign boxes.ready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= boxes.valid;
			end
			for (int k = 2; k <= 7; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign trig_en.s1 = adv[1];
	assign trig_en.s2 = adv[2];
	assign axis_en.s3 = adv[3];
	assign axis_en.s4 = adv[4];
	assign axis_en.s5 = adv[5];
	assign axis_en.s6 = adv[6];

	// trig lanes, one per box
	obbsat_trig u_trig_first (
		.clk     (clk),
		.en      (trig_en),
		.angle   (boxes.first_angle),
		.trig_s2 (trig_s2[0])
	);

	obbsat_trig u_trig_second (
		.clk     (clk),
		.en      (trig_en),
		.angle   (boxes.second_angle),
		.trig_s2 (trig_s2[1])
	);

	// centre offset and sizes travel alongside the trig lanes
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			dx_s1 <= DIFF_W'(boxes.second_center_x) - DIFF_W'(boxes.first_center_x);
			dy_s1 <= DIFF_W'(boxes.second_center_y) - DIFF_W'(boxes.first_center_y);
			size_x_s1[0] <= boxes.first_size_x;
			size_y_s1[0] <= boxes.first_size_y;
			size_x_s1[1] <= boxes.second_size_x;
			size_y_s1[1] <= boxes.second_size_y;
		end
		if (adv[2]) begin
			dx_s2     <= dx_s1;
			dy_s2     <= dy_s1;
			size_x_s2 <= size_x_s1;
			size_y_s2 <= size_y_s1;
		end
		if (adv[3]) begin
			size_x_s3 <= size_x_s2;
			size_y_s3 <= size_y_s2;
		end
		if (adv[4]) begin
			size_x_s4 <= size_x_s3;
			size_y_s4 <= size_y_s3;
		end
	end

	// the four candidate axes: local x and y of each box, unnormalised
	always_comb begin
		for (int b = 0; b < 2; b++) begin
			ax_ux[2*b]   = trig_s2[b].co;
			ax_uy[2*b]   = trig_s2[b].si;
			ax_ux[2*b+1] = -trig_s2[b].si;
			ax_uy[2*b+1] = trig_s2[b].co;
		end
	end

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		obbsat_axis u_axis (
			.clk    (clk),
			.en     (axis_en),
			.ux     (ax_ux[a]),
			.uy     (ax_uy[a]),
			.trig   (trig_s2),
			.dx     (dx_s2),
			.dy     (dy_s2),
			.size_x (size_x_s4),
			.size_y (size_y_s4),
			.sep_s6 (sep_s6[a])
		);
	end

	// merge: a gap on any axis separates the boxes; hold while the result waits
	always_ff @(posedge clk) begin
		if (adv[7]) begin
			overlap_q <= ~(|sep_s6);
		end
	end

	assign result.valid   = vld_q[7];
	assign result.overlap = overlap_q;

`ifndef SYNTHESIS
	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!boxes.ready |-> (&vld_q))
		else $error("input stalled while the pipeline holds a bubble");

	a_stall_from_output: assert property (@(posedge clk) disable iff (!arst_n)
		!boxes.ready |-> (result.valid && !result.ready))
		else $error("input stalled without a waiting result");

	a_result_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(vld_q[7]) |-> $past(vld_q[6]))
		else $error("result appeared without an item in the compare stage");
`endif

endmodule

/* tb/obbsat_overlap_checker.sv */
// Watches the box pair and result channels, predicts the overlap flag and compares.
`timescale 1ns / 1ps
module obbsat_overlap_checker import obbsat_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	obbsat_in_if.sink   boxes_mon,
	obbsat_out_if.sink  result_mon,
	output int          fail_count,
	output int          pending_count,
	output int          overlap_seen,
	output int          apart_seen
);
	localparam int QB = ANGLE_BITS - 2;
	localparam int QN = 1 << QB;

	typedef logic signed [127:0] wide_t;

	longint      sine_quarter [0:QN];
	logic        overlap_queue [$];
	int          result_index;

	// Quarter-wave table, rebuilt here from the Taylor series
	initial begin
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          s;
		longint          v;
		for (int k = 0; k <= QN; k++) begin
			x    = (longint'(k) * 64'd1686629713) >> QB;
			x2   = (x * x) >> 30;
			term = x;
			s    = longint'(x);
			for (int n = 1; n <= 10; n++) begin
				term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) begin
					s = s - longint'(term);
				end else begin
					s = s + longint'(term);
				end
			end
			if (s < 0) begin
				s = 0;
			end
			v = (s + (64'sd1 <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
			if (v > (64'sd1 <<< TRIG_FRAC_BITS)) begin
				v = 64'sd1 <<< TRIG_FRAC_BITS;
			end
			sine_quarter[k] = v;
		end
	end

	function automatic void angle_trig(input logic [ANGLE_BITS-1:0] a,
			output longint c, output longint s);
		int     r;
		longint lo;
		longint hi;
		r  = int'(a[QB-1:0]);
		lo = sine_quarter[r];
		hi = sine_quarter[QN - r];
		case (a[ANGLE_BITS-1 -: 2])
			2'd0: begin s = lo;  c = hi;  end
			2'd1: begin s = hi;  c = -lo; end
			2'd2: begin s = -lo; c = -hi; end
			default: begin s = -hi; c = lo; end
		endcase
	endfunction

	function automatic wide_t mag(input wide_t v);
		return (v < 0) ? -v : v;
	endfunction

	// Separating-axis test on the four unnormalised box axes
	function automatic logic boxes_overlap(input longint cx[2], input longint cy[2],
			input longint sx[2], input longint sy[2], input logic [ANGLE_BITS-1:0] ang[2]);
		longint co[2];
		longint si[2];
		longint ux;
		longint uy;
		wide_t  centre_gap;
		wide_t  reach;
		for (int b = 0; b < 2; b++) begin
			angle_trig(ang[b], co[b], si[b]);
		end
		for (int ax = 0; ax < 4; ax++) begin
			ux         = (ax % 2 == 1) ? -si[ax / 2] : co[ax / 2];
			uy         = (ax % 2 == 1) ? co[ax / 2] : si[ax / 2];
			centre_gap = mag(wide_t'(cx[1] - cx[0]) * ux + wide_t'(cy[1] - cy[0]) * uy);
			reach      = 0;
			for (int b = 0; b < 2; b++) begin
				reach += wide_t'(sx[b]) * mag(wide_t'(co[b]) * ux + wide_t'(si[b]) * uy);
				reach += wide_t'(sy[b]) * mag(wide_t'(co[b]) * uy - wide_t'(si[b]) * ux);
			end
			if ((centre_gap <<< (TRIG_FRAC_BITS + 1)) > reach) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch on result %0d: %s", $time, result_index, what);
		fail_count++;
	endtask

	initial begin
		fail_count    = 0;
		pending_count = 0;
		overlap_seen  = 0;
		apart_seen    = 0;
		result_index  = 0;
	end

	always @(posedge clk) begin
		longint                cx[2];
		longint                cy[2];
		longint                sx[2];
		longint                sy[2];
		logic [ANGLE_BITS-1:0] ang[2];
		logic                  want;
		if (arst_n && boxes_mon.valid && boxes_mon.ready) begin
			cx[0]  = longint'(boxes_mon.first_center_x);
			cy[0]  = longint'(boxes_mon.first_center_y);
			sx[0]  = longint'(boxes_mon.first_size_x);
			sy[0]  = longint'(boxes_mon.first_size_y);
			ang[0] = boxes_mon.first_angle;
			cx[1]  = longint'(boxes_mon.second_center_x);
			cy[1]  = longint'(boxes_mon.second_center_y);
			sx[1]  = longint'(boxes_mon.second_size_x);
			sy[1]  = longint'(boxes_mon.second_size_y);
			ang[1] = boxes_mon.second_angle;
			overlap_queue.push_back(boxes_overlap(cx, cy, sx, sy, ang));
		end
		if (arst_n && result_mon.valid && result_mon.ready) begin
			if (overlap_queue.size() == 0) begin
				report_mismatch("result with nothing expected");
			end else begin
				want = overlap_queue.pop_front();
				if (result_mon.overlap !== want) begin
					report_mismatch($sformatf("overlap %b, predicted %b",
						result_mon.overlap, want));
				end
			end
			if (result_mon.overlap === 1'b1) begin
				overlap_seen++;
			end else begin
				apart_seen++;
			end
			result_index++;
		end
		pending_count = overlap_queue.size();
	end
endmodule

/* tb/obb_pair_separating_axis_test_tb.sv */
// Stimulus and verdict for the oriented box pair overlap test.
`timescale 1ns / 1ps
module obb_pair_separating_axis_test_tb import obbsat_pkg::*; ();

	localparam int RANDOM_PAIRS = 1930;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HALF_C       = 1 << (COORD_BITS - 1);
	localparam int SIZE_MAX     = (1 << SIZE_BITS) - 1;

	localparam logic signed [COORD_BITS-1:0] COORD_MIN = COORD_BITS'(-HALF_C);
	localparam logic signed [COORD_BITS-1:0] COORD_MAX = COORD_BITS'(HALF_C - 1);

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending_count;
	int   overlap_seen;
	int   apart_seen;
	int   cycle_count;
	int   pairs_sent;
	bit   long_hold;

	obbsat_in_if  boxes ();
	obbsat_out_if result ();

	obb_pair_separating_axis_test DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.boxes  (boxes.sink),
		.result (result.source)
	);

	obbsat_overlap_checker checker_inst (
		.clk           (clk),
		.arst_n        (arst_n),
		.boxes_mon     (boxes.sink),
		.result_mon    (result.sink),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.overlap_seen  (overlap_seen),
		.apart_seen    (apart_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Mostly no gap, often a short one, now and then a long one
	function automatic int gap_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			return 0;
		end else if (roll < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [COORD_BITS-1:0] pick_coord(input int spread);
		case ($urandom_range(0, 9))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2: return COORD_BITS'($urandom);
			default: return COORD_BITS'($signed($urandom_range(0, 2 * spread)) - spread);
		endcase
	endfunction

	function automatic logic [SIZE_BITS-1:0] pick_size(input int spread);
		case ($urandom_range(0, 11))
			0: return '0;
			1: return SIZE_BITS'(SIZE_MAX);
			2: return SIZE_BITS'($urandom);
			default: return SIZE_BITS'($urandom_range(0, spread));
		endcase
	endfunction

	function automatic logic [ANGLE_BITS-1:0] pick_angle();
		case ($urandom_range(0, 5))
			0: return ANGLE_BITS'($urandom_range(0, 3) * QUARTER);
			1: return ANGLE_BITS'($urandom_range(0, 3) * QUARTER + $urandom_range(0, 1) * 2
				* $urandom_range(0, QUARTER / 2) - 1);
			default: return ANGLE_BITS'($urandom);
		endcase
	endfunction

	// Offer one pair and hold it until the block takes it
	task automatic send_pair(
		input logic signed [COORD_BITS-1:0] ax, input logic signed [COORD_BITS-1:0] ay,
		input logic [SIZE_BITS-1:0] aw, input logic [SIZE_BITS-1:0] ah,
		input logic [ANGLE_BITS-1:0] aa,
		input logic signed [COORD_BITS-1:0] bx, input logic signed [COORD_BITS-1:0] by,
		input logic [SIZE_BITS-1:0] bw, input logic [SIZE_BITS-1:0] bh,
		input logic [ANGLE_BITS-1:0] ba);
		int gap;
		gap = gap_length();
		if (gap > 0) begin
			boxes.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		boxes.valid           <= 1'b1;
		boxes.first_center_x  <= ax;
		boxes.first_center_y  <= ay;
		boxes.first_size_x    <= aw;
		boxes.first_size_y    <= ah;
		boxes.first_angle     <= aa;
		boxes.second_center_x <= bx;
		boxes.second_center_y <= by;
		boxes.second_size_x   <= bw;
		boxes.second_size_y   <= bh;
		boxes.second_angle    <= ba;
		do @(posedge clk); while (!boxes.ready);
		pairs_sent++;
	endtask

	// Random pair: mostly boxes of similar scale near each other, so both verdicts turn up
	task automatic send_random_pair();
		int spread;
		spread = 1 << $urandom_range(4, 22);
		send_pair(pick_coord(spread), pick_coord(spread), pick_size(spread),
			pick_size(spread), pick_angle(), pick_coord(spread), pick_coord(spread),
			pick_size(spread), pick_size(spread), pick_angle());
	endtask

	// Receiver: random stalls, with one long hold-off set by the stimulus
	initial begin
		int stall;
		result.ready <= 1'b0;
		wait (arst_n);
		forever begin
			if (long_hold) begin
				result.ready <= 1'b0;
				repeat (300) @(posedge clk);
				long_hold = 1'b0;
			end
			stall = ($urandom_range(0, 3) == 0) ? gap_length() : 0;
			if (stall > 0) begin
				result.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result.ready <= 1'b1;
			@(posedge clk);
		end
	end

	// Watchdog
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d results outstanding",
					cycle_count, pending_count);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		int wait_cycles;
		pairs_sent    = 0;
		long_hold     = 1'b0;
		arst_n        = 1'b0;
		boxes.valid           <= 1'b0;
		boxes.first_center_x  <= '0;
		boxes.first_center_y  <= '0;
		boxes.first_size_x    <= '0;
		boxes.first_size_y    <= '0;
		boxes.first_angle     <= '0;
		boxes.second_center_x <= '0;
		boxes.second_center_y <= '0;
		boxes.second_size_x   <= '0;
		boxes.second_size_y   <= '0;
		boxes.second_angle    <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: identical boxes, touching edges, a hair apart, points and segments
		send_pair(0, 0, 256, 256, 0, 0, 0, 256, 256, 0);
		send_pair(0, 0, 512, 512, 0, 512, 0, 512, 512, 0);
		send_pair(0, 0, 512, 512, 0, 513, 0, 512, 512, 0);
		send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_pair(0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
		send_pair(0, 0, 0, 0, 512, 0, 100, 0, 400, 0);
		send_pair(0, 0, 1000, 0, 512, 0, 300, 0, 1000, 1024);
		send_pair(0, 0, 1000, 1000, 1024, 0, 600, 200, 200, 2048);
		send_pair(0, 0, 1000, 1000, 3072, 800, 800, 200, 200, 3583);
		send_pair(0, 0, 1000, 1000, 512, 700, 0, 400, 400, 512);
		send_pair(0, 0, 1000, 1000, 512, 1200, 0, 400, 400, 0);
		send_pair(COORD_MIN, COORD_MIN, SIZE_BITS'(SIZE_MAX), SIZE_BITS'(SIZE_MAX), 4095,
			COORD_MAX, COORD_MAX, SIZE_BITS'(SIZE_MAX), SIZE_BITS'(SIZE_MAX), 1);
		send_pair(COORD_MIN, COORD_MAX, 0, 0, 0, COORD_MAX, COORD_MIN, 0, 0, 4095);
		send_pair(COORD_MAX, COORD_MIN, 256, 256, 2047, COORD_MIN, COORD_MAX, 256, 256, 2048);
		send_pair(COORD_MIN, COORD_MIN, SIZE_BITS'(SIZE_MAX), 0, 1023,
			COORD_MIN, COORD_MIN, 0, SIZE_BITS'(SIZE_MAX), 3073);
		send_pair(24'h555555, 24'hAAAAAA, 23'h2AAAAA, 23'h555555, 12'hAAA,
			24'hAAAAAA, 24'h555555, 23'h555555, 23'h2AAAAA, 12'h555);

		// Random pairs, with one long receiver hold-off a third of the way in
		for (int i = 0; i < RANDOM_PAIRS; i++) begin
			if (i == RANDOM_PAIRS / 3) begin
				long_hold = 1'b1;
			end
			send_random_pair();
		end
		boxes.valid <= 1'b0;

		wait_cycles = 0;
		while (pending_count != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (20) @(posedge clk);

		$display("sent %0d box pairs; %0d results overlapped, %0d were apart",
			pairs_sent, overlap_seen, apart_seen);
		if (fail_count == 0 && pending_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches, %0d results never arrived", fail_count, pending_count);
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
